[src/aae_pkg.sv]
`default_nettype none
package aae_pkg;

   localparam int PRECISION_BITS = 15;
   localparam int MAX_SYMBOLS_DEFAULT = 258;

   localparam int BOUND_W = 18;
   localparam int FREQ_W = 16;
   localparam int PEND_W = 16;
   localparam int ALPHA_W = 9;
   localparam int SYM_W = 9;
   localparam int MODE_W = 2;
   localparam int DIVIDEND_W = BOUND_W + FREQ_W;

   localparam logic [BOUND_W-1:0] Q1 = BOUND_W'(1 << PRECISION_BITS);
   localparam logic [BOUND_W-1:0] Q2 = BOUND_W'(2 << PRECISION_BITS);
   localparam logic [BOUND_W-1:0] Q3 = BOUND_W'(3 << PRECISION_BITS);
   localparam logic [BOUND_W-1:0] Q4 = BOUND_W'(4 << PRECISION_BITS);
   localparam logic [FREQ_W-1:0] MAX_CUM = FREQ_W'((1 << PRECISION_BITS) - 1);

   localparam int RENORM_LIMIT = PRECISION_BITS + 2;
   localparam int ROUND_W = $clog2(RENORM_LIMIT + 1);

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd256;

   localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

   typedef struct packed {
      logic rd;
      logic wr;
   } mem_ctl_type;

endpackage
`default_nettype wire

[src/aae_divider.sv]
`default_nettype none
module aae_divider (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire [aae_pkg::DIVIDEND_W-1:0]    dividend,
   input  wire [aae_pkg::FREQ_W-1:0]        divisor,
   output logic                             done,
   output logic [aae_pkg::DIVIDEND_W-1:0]   quotient
);
   import aae_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [FREQ_W-1:0]     rem_ff, rem_in;
   logic [FREQ_W-1:0]     dvs_ff, dvs_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [FREQ_W:0]       rem_sh;
   logic                  ge;

   // one restoring step a cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         dvs_in = divisor;
         quo_in = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? FREQ_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[FREQ_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[src/aae_model_mem.sv]
`default_nettype none
module aae_model_mem #(
   parameter int MAX_SYMBOLS = aae_pkg::MAX_SYMBOLS_DEFAULT,
   parameter int RANK_W = $clog2(MAX_SYMBOLS + 1),
   parameter int CHAR_W = $clog2(MAX_SYMBOLS),
   parameter int ENT_W = 2 * aae_pkg::FREQ_W + CHAR_W
) (
   input  wire                       clock,
   input  aae_pkg::mem_ctl_type      a_ctl,
   input  wire [RANK_W-1:0]          a_addr,
   input  wire [ENT_W-1:0]           a_wdata,
   output logic [ENT_W-1:0]          a_rdata,
   input  aae_pkg::mem_ctl_type      b_ctl,
   input  wire [CHAR_W-1:0]          b_addr,
   input  wire [RANK_W-1:0]          b_wdata,
   output logic [RANK_W-1:0]         b_rdata
);
   import aae_pkg::*;

   // rank table: count, cumulative count and character per rank
   logic [ENT_W-1:0]  rank_mem [MAX_SYMBOLS + 1];
   // character table: rank per character
   logic [RANK_W-1:0] char_mem [MAX_SYMBOLS];
   logic [ENT_W-1:0]  a_rdata_ff;
   logic [RANK_W-1:0] b_rdata_ff;

   always_ff @(posedge clock) begin
      if (a_ctl.wr) begin
         rank_mem[a_addr] <= a_wdata;
      end
      if (a_ctl.rd) begin
         a_rdata_ff <= rank_mem[a_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (b_ctl.wr) begin
         char_mem[b_addr] <= b_wdata;
      end
      if (b_ctl.rd) begin
         b_rdata_ff <= char_mem[b_addr];
      end
   end

   assign a_rdata = a_rdata_ff;
   assign b_rdata = b_rdata_ff;

endmodule
`default_nettype wire

[src/adaptive_arith_encoder_top.sv]
`default_nettype none
// Encode beat: two divisions (34 restoring steps each), one renormalisation round a cycle,
// then in the memory a halving pass once the total reaches MAX_CUM, a rank walk and a count
// walk. Back-pressure on rsp_ready stretches renormalisation. Flush beat: one result, marked
// last. Restart beat and reset: a pass that lays the uniform model into both memories,
// req_ready low; configuration writes still land. One beat in flight at a time.
module adaptive_arith_encoder_top #(
   parameter int MAX_SYMBOLS = aae_pkg::MAX_SYMBOLS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [aae_pkg::MODE_W-1:0]    req_mode,
   input  wire [aae_pkg::SYM_W-1:0]     req_symbol,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_out_bit,
   output logic [aae_pkg::PEND_W-1:0]   rsp_follow_count,
   output logic                         rsp_last,
   input  wire                          csr_we,
   input  wire [aae_pkg::ALPHA_W-1:0]   csr_wdata
);
   import aae_pkg::*;

   localparam int RANK_W = $clog2(MAX_SYMBOLS + 1);
   localparam int CHAR_W = $clog2(MAX_SYMBOLS);
   localparam int ENT_W = 2 * FREQ_W + CHAR_W;
   localparam int SYM_LSB = 0;
   localparam int CUM_LSB = FREQ_W;
   localparam int CHR_LSB = 2 * FREQ_W;
   localparam int ACTIVE_RESET_I = (MAX_SYMBOLS < 256) ? MAX_SYMBOLS : 256;
   localparam logic [RANK_W-1:0] ACTIVE_RESET = RANK_W'(ACTIVE_RESET_I);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_FLUSH, S_RANK, S_RD0, S_RD1, S_RD2, S_MUL, S_DIVGO, S_DIVW,
      S_REN, S_FIN, S_UPD, S_HRD, S_HWR, S_H0R, S_H0W, S_SRCH0, S_SRCH1, S_SRCH2,
      S_SWP, S_SWP1, S_SWP2, S_WRI, S_B1, S_B2, S_IRD, S_IWR
   } state_type;

   state_type             state_ff, state_in;
   logic [RANK_W-1:0]     idx_ff, idx_in;
   logic [ALPHA_W-1:0]    alpha_ff, alpha_in;
   logic [RANK_W-1:0]     active_ff, active_in;
   logic [BOUND_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [PEND_W-1:0]     pend_ff, pend_in;
   logic [RANK_W-1:0]     r_ff, r_in, i_ff, i_in;
   logic [FREQ_W-1:0]     cum0_ff, cum0_in, chi_ff, chi_in, clo_ff, clo_in;
   logic [FREQ_W-1:0]     symr_ff, symr_in, c_ff, c_in;
   logic [BOUND_W-1:0]    span_ff, span_in, wlo_ff, wlo_in, whi_ff, whi_in;
   logic [DIVIDEND_W-1:0] prod_ff, prod_in;
   logic                  second_ff, second_in;
   logic [ROUND_W-1:0]    rounds_ff, rounds_in;
   logic                  hold_valid_ff, hold_valid_in, hold_bit_ff, hold_bit_in;
   logic [PEND_W-1:0]     hold_cnt_ff, hold_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in, rsp_bit_ff, rsp_bit_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [PEND_W-1:0]     rsp_cnt_ff, rsp_cnt_in;
   logic [ENT_W-1:0]      enti_ff, enti_in;
   logic [CHAR_W-1:0]     cr_ff, cr_in;

   mem_ctl_type           a_ctl, b_ctl;
   logic [RANK_W-1:0]     a_addr;
   logic [ENT_W-1:0]      a_wdata, a_rdata;
   logic [CHAR_W-1:0]     b_addr;
   logic [RANK_W-1:0]     b_wdata, b_rdata;

   logic                  div_start, div_done;
   logic [DIVIDEND_W-1:0] div_q;
   logic [FREQ_W-1:0]     total;

   logic                  slot_free;
   logic [PEND_W-1:0]     pend_inc;
   logic [RANK_W-1:0]     clamp_n;
   logic [FREQ_W-1:0]     rd_sym, rd_cum;
   logic [CHAR_W-1:0]     rd_chr, ci;
   logic [FREQ_W:0]       half_wide;
   logic [FREQ_W-1:0]     half;
   logic [BOUND_W-1:0]    div_sum, sub, tlo, thi;
   logic                  emit0, emit1, under;

   aae_model_mem #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .RANK_W      (RANK_W),
      .CHAR_W      (CHAR_W),
      .ENT_W       (ENT_W)
   ) u_mem (
      .clock   (clock),
      .a_ctl   (a_ctl),
      .a_addr  (a_addr),
      .a_wdata (a_wdata),
      .a_rdata (a_rdata),
      .b_ctl   (b_ctl),
      .b_addr  (b_addr),
      .b_wdata (b_wdata),
      .b_rdata (b_rdata)
   );

   // a zero total divides as if it were one
   assign total = (cum0_ff == '0) ? FREQ_W'(1) : cum0_ff;

   aae_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (total),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      pend_inc = (pend_ff == '1) ? pend_ff : pend_ff + 1'b1;
      if (alpha_ff < ALPHA_W'(2)) begin
         clamp_n = RANK_W'(2);
      end else if (32'(alpha_ff) > MAX_SYMBOLS) begin
         clamp_n = RANK_W'(MAX_SYMBOLS);
      end else begin
         clamp_n = RANK_W'(alpha_ff);
      end
      rd_sym = a_rdata[SYM_LSB +: FREQ_W];
      rd_cum = a_rdata[CUM_LSB +: FREQ_W];
      rd_chr = a_rdata[CHR_LSB +: CHAR_W];
      ci = enti_ff[CHR_LSB +: CHAR_W];
      half_wide = {1'b0, rd_sym} + 1'b1;
      half = half_wide[FREQ_W:1];
      div_sum = lo_ff + BOUND_W'(div_q);
      // renormalisation decision on the working bounds
      emit0 = whi_ff <= Q2;
      emit1 = !emit0 && (wlo_ff >= Q2);
      under = !emit0 && !emit1 && (wlo_ff >= Q1) && (whi_ff <= Q3);
      sub = emit1 ? Q2 : (under ? Q1 : '0);
      tlo = wlo_ff - sub;
      thi = whi_ff - sub;
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      alpha_in = csr_we ? csr_wdata : alpha_ff;
      active_in = active_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      pend_in = pend_ff;
      r_in = r_ff;
      i_in = i_ff;
      cum0_in = cum0_ff;
      chi_in = chi_ff;
      clo_in = clo_ff;
      symr_in = symr_ff;
      c_in = c_ff;
      span_in = span_ff;
      wlo_in = wlo_ff;
      whi_in = whi_ff;
      prod_in = prod_ff;
      second_in = second_ff;
      rounds_in = rounds_ff;
      hold_valid_in = hold_valid_ff;
      hold_bit_in = hold_bit_ff;
      hold_cnt_in = hold_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bit_in = rsp_bit_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_last_in = rsp_last_ff;
      enti_in = enti_ff;
      cr_in = cr_ff;
      a_ctl = '0;
      a_addr = '0;
      a_wdata = '0;
      b_ctl = '0;
      b_addr = '0;
      b_wdata = '0;
      div_start = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            // lay down the uniform model, one rank and one character a cycle
            a_ctl.wr = 1'b1;
            a_addr = idx_ff;
            a_wdata[SYM_LSB +: FREQ_W] =
               (idx_ff != '0 && idx_ff <= active_ff) ? FREQ_W'(1) : '0;
            a_wdata[CUM_LSB +: FREQ_W] =
               (idx_ff < active_ff) ? FREQ_W'(active_ff - idx_ff) : '0;
            a_wdata[CHR_LSB +: CHAR_W] = (idx_ff == '0) ? '0 : CHAR_W'(idx_ff - 1'b1);
            if (32'(idx_ff) < MAX_SYMBOLS) begin
               b_ctl.wr = 1'b1;
               b_addr = CHAR_W'(idx_ff);
               b_wdata = idx_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (32'(idx_ff) == MAX_SYMBOLS) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_RESTART: begin
                     active_in = clamp_n;
                     idx_in = '0;
                     lo_in = '0;
                     hi_in = Q4;
                     pend_in = '0;
                     state_in = S_INIT;
                  end
                  MODE_FLUSH: begin
                     state_in = S_FLUSH;
                  end
                  MODE_ENCODE: begin
                     if ((32'(req_symbol) < 32'(active_ff)) &&
                         (32'(req_symbol) < MAX_SYMBOLS)) begin
                        b_ctl.rd = 1'b1;
                        b_addr = CHAR_W'(req_symbol);
                        state_in = S_RANK;
                     end
                  end
                  default: begin
                     // unused mode: drop the beat
                  end
               endcase
            end
         end
         S_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in = lo_ff >= Q1;
               rsp_cnt_in = pend_inc;
               rsp_last_in = 1'b1;
               pend_in = '0;
               state_in = S_IDLE;
            end
         end
         S_RANK: begin
            if (b_rdata == '0 || b_rdata > active_ff) begin
               state_in = S_IDLE;
            end else begin
               r_in = b_rdata;
               a_ctl.rd = 1'b1;
               a_addr = '0;
               state_in = S_RD0;
            end
         end
         S_RD0: begin
            cum0_in = rd_cum;
            span_in = (hi_ff > lo_ff) ? hi_ff - lo_ff : '0;
            a_ctl.rd = 1'b1;
            a_addr = r_ff - 1'b1;
            state_in = S_RD1;
         end
         S_RD1: begin
            chi_in = rd_cum;
            a_ctl.rd = 1'b1;
            a_addr = r_ff;
            state_in = S_RD2;
         end
         S_RD2: begin
            clo_in = rd_cum;
            second_in = 1'b0;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = DIVIDEND_W'(span_ff) * DIVIDEND_W'(second_ff ? clo_ff : chi_ff);
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               if (!second_ff) begin
                  whi_in = div_sum;
                  second_in = 1'b1;
                  state_in = S_MUL;
               end else begin
                  wlo_in = div_sum;
                  rounds_in = '0;
                  state_in = S_REN;
               end
            end
         end
         S_REN: begin
            if (rounds_ff == ROUND_W'(RENORM_LIMIT) || !(emit0 || emit1 || under)) begin
               lo_in = wlo_ff;
               hi_in = whi_ff;
               state_in = S_FIN;
            end else if (under) begin
               pend_in = pend_inc;
               wlo_in = {tlo[BOUND_W-2:0], 1'b0};
               whi_in = {thi[BOUND_W-2:0], 1'b0};
               rounds_in = rounds_ff + 1'b1;
            end else if (!hold_valid_ff || slot_free) begin
               // push the held bit out, keep the new one until we know if it is last
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_bit_in = hold_bit_ff;
                  rsp_cnt_in = hold_cnt_ff;
                  rsp_last_in = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_bit_in = emit1;
               hold_cnt_in = pend_ff;
               pend_in = '0;
               wlo_in = {tlo[BOUND_W-2:0], 1'b0};
               whi_in = {thi[BOUND_W-2:0], 1'b0};
               rounds_in = rounds_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (!hold_valid_ff) begin
               state_in = S_UPD;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in = hold_bit_ff;
               rsp_cnt_in = hold_cnt_ff;
               rsp_last_in = 1'b1;
               hold_valid_in = 1'b0;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (cum0_ff >= MAX_CUM) begin
               idx_in = active_ff;
               c_in = '0;
               state_in = S_HRD;
            end else begin
               state_in = S_SRCH0;
            end
         end
         S_HRD: begin
            a_ctl.rd = 1'b1;
            a_addr = idx_ff;
            state_in = S_HWR;
         end
         S_HWR: begin
            // halve the count, rounding up, and rebuild the cumulative count from the top
            a_ctl.wr = 1'b1;
            a_addr = idx_ff;
            a_wdata = a_rdata;
            a_wdata[SYM_LSB +: FREQ_W] = half;
            a_wdata[CUM_LSB +: FREQ_W] = c_ff;
            c_in = c_ff + half;
            idx_in = idx_ff - 1'b1;
            state_in = (idx_ff == RANK_W'(1)) ? S_H0R : S_HRD;
         end
         S_H0R: begin
            a_ctl.rd = 1'b1;
            a_addr = '0;
            state_in = S_H0W;
         end
         S_H0W: begin
            a_ctl.wr = 1'b1;
            a_addr = '0;
            a_wdata = a_rdata;
            a_wdata[CUM_LSB +: FREQ_W] = c_ff;
            state_in = S_SRCH0;
         end
         S_SRCH0: begin
            a_ctl.rd = 1'b1;
            a_addr = r_ff;
            i_in = r_ff;
            state_in = S_SRCH1;
         end
         S_SRCH1: begin
            symr_in = rd_sym;
            if (i_ff > RANK_W'(1)) begin
               a_ctl.rd = 1'b1;
               a_addr = i_ff - 1'b1;
               state_in = S_SRCH2;
            end else begin
               state_in = S_SWP;
            end
         end
         S_SRCH2: begin
            // walk forward past ranks with an equal count
            if (rd_sym == symr_ff) begin
               i_in = i_ff - 1'b1;
               if (i_ff > RANK_W'(2)) begin
                  a_ctl.rd = 1'b1;
                  a_addr = i_ff - RANK_W'(2);
               end else begin
                  state_in = S_SWP;
               end
            end else begin
               state_in = S_SWP;
            end
         end
         S_SWP: begin
            a_ctl.rd = 1'b1;
            a_addr = i_ff;
            state_in = S_SWP1;
         end
         S_SWP1: begin
            enti_in = a_rdata;
            a_ctl.rd = 1'b1;
            a_addr = r_ff;
            state_in = S_SWP2;
         end
         S_SWP2: begin
            cr_in = rd_chr;
            if (i_ff < r_ff) begin
               a_ctl.wr = 1'b1;
               a_addr = r_ff;
               a_wdata = a_rdata;
               a_wdata[CHR_LSB +: CHAR_W] = ci;
            end
            state_in = S_WRI;
         end
         S_WRI: begin
            a_ctl.wr = 1'b1;
            a_addr = i_ff;
            a_wdata = enti_ff;
            a_wdata[SYM_LSB +: FREQ_W] = enti_ff[SYM_LSB +: FREQ_W] + 1'b1;
            if (i_ff < r_ff) begin
               a_wdata[CHR_LSB +: CHAR_W] = cr_ff;
               state_in = S_B1;
            end else begin
               idx_in = '0;
               state_in = S_IRD;
            end
         end
         S_B1: begin
            if (32'(ci) < MAX_SYMBOLS) begin
               b_ctl.wr = 1'b1;
               b_addr = ci;
               b_wdata = r_ff;
            end
            state_in = S_B2;
         end
         S_B2: begin
            if (32'(cr_ff) < MAX_SYMBOLS) begin
               b_ctl.wr = 1'b1;
               b_addr = cr_ff;
               b_wdata = i_ff;
            end
            idx_in = '0;
            state_in = S_IRD;
         end
         S_IRD: begin
            a_ctl.rd = 1'b1;
            a_addr = idx_ff;
            state_in = S_IWR;
         end
         S_IWR: begin
            // advance every cumulative count in front of the updated rank
            a_ctl.wr = 1'b1;
            a_addr = idx_ff;
            a_wdata = a_rdata;
            a_wdata[CUM_LSB +: FREQ_W] = rd_cum + 1'b1;
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == i_ff) ? S_IDLE : S_IRD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         idx_ff <= '0;
         alpha_ff <= ALPHA_RESET;
         active_ff <= ACTIVE_RESET;
         lo_ff <= '0;
         hi_ff <= Q4;
         pend_ff <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         alpha_ff <= alpha_in;
         active_ff <= active_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         pend_ff <= pend_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff <= r_in;
      i_ff <= i_in;
      cum0_ff <= cum0_in;
      chi_ff <= chi_in;
      clo_ff <= clo_in;
      symr_ff <= symr_in;
      c_ff <= c_in;
      span_ff <= span_in;
      wlo_ff <= wlo_in;
      whi_ff <= whi_in;
      prod_ff <= prod_in;
      second_ff <= second_in;
      rounds_ff <= rounds_in;
      hold_bit_ff <= hold_bit_in;
      hold_cnt_ff <= hold_cnt_in;
      rsp_bit_ff <= rsp_bit_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
      enti_ff <= enti_in;
      cr_ff <= cr_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_bit = rsp_bit_ff;
   assign rsp_follow_count = rsp_cnt_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_hold_empty_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !hold_valid_ff)
      else $error("held result left behind in idle");
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVW)
      else $error("divider finished outside its wait state");
   a_restart_sweep: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_RESTART |=> state_ff == S_INIT)
      else $error("restart beat did not start the clearing pass");
`endif

endmodule
`default_nettype wire

[tb/adaptive_arith_encoder_top_tb.sv]
`default_nettype none
module adaptive_arith_encoder_top_tb;
   import aae_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 1600;  // slowest encode beat: halving, rank walk, count walk
   localparam int STALL_LIMIT = 20000;   // cycles with no beat on either channel
   localparam int LONG_HOLD = 3000;
   localparam int RAND_PER_PHASE = 22;

   // Expected coded runs, plus a bit-true copy of the encoder state
   class encoder_scoreboard;
      typedef struct {
         bit        out_bit;
         bit [15:0] follow;
         bit        last;
      } coded_run_type;

      coded_run_type     runs_due[$];
      int                errors;
      bit [ALPHA_W-1:0]  alpha_reg;
      int unsigned       n_act;
      longint unsigned   low_b, high_b;
      int unsigned       pend;
      bit [15:0]         freq[0:258];
      bit [15:0]         cum[0:258];
      bit [15:0]         c2r[0:257];
      bit [15:0]         r2c[0:258];

      function new();
         errors = 0;
         alpha_reg = ALPHA_RESET;
         restart_model();
      endfunction

      function void restart_model();
         n_act = alpha_reg;
         if (n_act < 2) n_act = 2;
         if (n_act > 258) n_act = 258;
         for (int i = 0; i <= 258; i++) begin
            freq[i] = 0;
            cum[i] = 0;
            r2c[i] = (i == 0) ? 16'd0 : 16'(i - 1);
         end
         for (int i = 0; i < 258; i++) c2r[i] = 16'(i + 1);
         for (int i = 1; i <= n_act; i++) begin
            freq[i] = 1;
            cum[i - 1] = 16'(n_act - i + 1);
         end
         low_b = 0;
         high_b = Q4;
         pend = 0;
      endfunction

      function void push_run(bit b);
         coded_run_type run;
         run.out_bit = b;
         run.follow = 16'(pend);
         run.last = 1'b0;
         runs_due.push_back(run);
         pend = 0;
      endfunction

      function void bump_pending();
         if (pend < 65535) pend++;
      endfunction

      function void adapt(int unsigned r);
         int unsigned i;
         int unsigned c;
         bit [15:0]   ci, cr;
         // halve all counts once the total hits the ceiling
         if (cum[0] >= MAX_CUM) begin
            c = 0;
            for (i = n_act; i > 0; i--) begin
               cum[i] = 16'(c);
               freq[i] = 16'((32'(freq[i]) + 1) >> 1);
               c += freq[i];
            end
            cum[0] = 16'(c);
         end
         i = r;
         while (i > 1 && freq[i] == freq[i - 1]) i--;
         if (i < r) begin
            ci = r2c[i];
            cr = r2c[r];
            r2c[i] = cr;
            r2c[r] = ci;
            if (ci < 258) c2r[ci] = 16'(r);
            if (cr < 258) c2r[cr] = 16'(i);
         end
         freq[i] = freq[i] + 16'd1;
         for (int j = 0; j < i; j++) cum[j] = cum[j] + 16'd1;
      endfunction

      // note an accepted input beat and queue the runs it must produce
      function void note_beat(bit [MODE_W-1:0] mode, bit [SYM_W-1:0] sym);
         int unsigned     first, r;
         longint unsigned total, span, lo, hi;
         first = runs_due.size();
         if (mode == MODE_RESTART) begin
            restart_model();
            return;
         end
         if (mode == MODE_FLUSH) begin
            bump_pending();
            push_run(low_b < Q1 ? 1'b0 : 1'b1);
            runs_due[$].last = 1'b1;
            return;
         end
         if (mode != MODE_ENCODE) return;
         if (sym >= n_act) return;
         r = c2r[sym];
         if (r < 1 || r > n_act) return;
         total = (cum[0] != 0) ? cum[0] : 1;
         lo = low_b;
         hi = high_b;
         span = (hi > lo) ? hi - lo : 0;
         hi = lo + (span * cum[r - 1]) / total;
         lo = lo + (span * cum[r]) / total;
         for (int k = 0; k < RENORM_LIMIT; k++) begin
            if (hi <= Q2) push_run(1'b0);
            else if (lo >= Q2) begin
               push_run(1'b1);
               lo -= Q2;
               hi -= Q2;
            end else if (lo >= Q1 && hi <= Q3) begin
               bump_pending();
               lo -= Q1;
               hi -= Q1;
            end else break;
            lo = (lo << 1) & 64'h3FFFF;
            hi = (hi << 1) & 64'h3FFFF;
         end
         low_b = lo & 64'h3FFFF;
         high_b = hi & 64'h3FFFF;
         adapt(r);
         if (runs_due.size() > first) runs_due[$].last = 1'b1;
      endfunction

      function void check_result(bit b, bit [15:0] f, bit l);
         coded_run_type run;
         if (runs_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected result bit=%0d follow=%0d last=%0d", $time, b, f, l);
            return;
         end
         run = runs_due.pop_front();
         if (run.out_bit !== b || run.follow !== f || run.last !== l) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: mismatch exp bit=%0d follow=%0d last=%0d,",
                         " got bit=%0d follow=%0d last=%0d"},
                        $time, run.out_bit, run.follow, run.last, b, f, l);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode;
   logic [SYM_W-1:0]    req_symbol;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_out_bit;
   logic [PEND_W-1:0]   rsp_follow_count;
   logic                rsp_last;
   logic                csr_we;
   logic [ALPHA_W-1:0]  csr_wdata;

   encoder_scoreboard   sb;
   int                  hold_cycles;
   int                  rsp_gap;
   int                  quiet_cycles;

   adaptive_arith_encoder_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_symbol       (req_symbol),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_bit      (rsp_out_bit),
      .rsp_follow_count (rsp_follow_count),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 10);
      return $urandom_range(30, 80);
   endfunction

   // Result side: check every beat at the rising edge, move ready at the falling edge
   initial begin
      rsp_ready = 1'b0;
      rsp_gap = 0;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_out_bit, rsp_follow_count, rsp_last);
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else if (rsp_gap > 0) begin
            rsp_ready = 1'b0;
            rsp_gap--;
         end else begin
            rsp_ready = 1'b1;
            if ($urandom_range(0, 7) == 0) rsp_gap = pick_gap();
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("adaptive_arith_encoder_top_tb: done, errors");
         $finish;
      end
   end

   // Offer one beat, hold it until accepted, then drop valid
   task automatic send_beat(input bit [MODE_W-1:0] mode, input bit [SYM_W-1:0] sym);
      req_mode = mode;
      req_symbol = sym;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_beat(mode, sym);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic sender_gap();
      if ($urandom_range(0, 3) == 0) repeat (pick_gap()) @(negedge clock);
   endtask

   // Wait for every expected run, then let a silent encode finish
   task automatic settle();
      while (sb.runs_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_alphabet(input bit [ALPHA_W-1:0] v);
      csr_we = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      sb.alpha_reg = v;
   endtask

   task automatic random_beats(input int count);
      int r;
      int hot;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         hot = (sb.n_act > 8) ? 7 : sb.n_act - 1;
         if (r < 80) begin
            // skew towards a few symbols so the ranking keeps reordering
            if ($urandom_range(0, 3) == 0)
               send_beat(MODE_ENCODE, $urandom_range(0, sb.n_act - 1));
            else send_beat(MODE_ENCODE, $urandom_range(0, hot));
         end else if (r < 88) send_beat(MODE_FLUSH, $urandom);
         else if (r < 91) send_beat(MODE_RESTART, $urandom);
         else if (r < 94) send_beat(MODE_UNUSED, $urandom);
         else send_beat(MODE_ENCODE, $urandom_range(sb.n_act, 511));
         sender_gap();
      end
   endtask

   task automatic directed_beats();
      send_beat(MODE_FLUSH, 9'd0);                // flush from a fresh interval
      send_beat(MODE_ENCODE, 9'd0);
      send_beat(MODE_ENCODE, 9'(sb.n_act - 1));
      send_beat(MODE_ENCODE, 9'(sb.n_act));       // just outside the alphabet: ignored
      send_beat(MODE_ENCODE, 9'h1FF);
      send_beat(MODE_UNUSED, 9'h1FF);             // unused mode: ignored
      repeat (6) send_beat(MODE_ENCODE, 9'd5);    // walk one symbol forward past equals
      send_beat(MODE_ENCODE, 9'd200);
      send_beat(MODE_ENCODE, 9'd255);
      send_beat(MODE_FLUSH, 9'h155);
      send_beat(MODE_RESTART, 9'h0AA);
      send_beat(MODE_ENCODE, 9'd128);
      send_beat(MODE_ENCODE, 9'd64);
      send_beat(MODE_FLUSH, 9'd0);
   endtask

   initial begin
      bit [ALPHA_W-1:0] alpha_list[7];
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_ENCODE;
      req_symbol = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      alpha_list = '{9'd256, 9'd2, 9'd0, 9'd258, 9'd511, 9'd3, 9'($urandom_range(4, 300))};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < 7; p++) begin
         settle();
         write_alphabet(alpha_list[p]);
         send_beat(MODE_RESTART, $urandom);
         if (p == 0) directed_beats();
         if (p == 1) begin
            // starve the result side while beats keep coming, then drain fully
            hold_cycles = LONG_HOLD;
            repeat (6) send_beat(MODE_ENCODE, $urandom_range(0, 1));
            settle();
         end
         random_beats(RAND_PER_PHASE);
      end

      settle();
      if (sb.errors == 0 && sb.runs_due.size() == 0)
         $display("adaptive_arith_encoder_top_tb: done, clean");
      else
         $display("adaptive_arith_encoder_top_tb: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
